@@ sv/trv_pkg.sv @@
// Shared types, constants and the state-load helper for the Trivium-80 keystream block.
// No dependencies; the datapath, controller and top level use this package.
package trv_pkg;

	// state and round geometry
	localparam int STATE_BITS       = 288;
	localparam int KEY_BITS         = 80;
	localparam int IV_BASE          = 93;
	localparam int WARMUP_ROUNDS    = 1152;
	localparam int ROUNDS_PER_CYCLE = 8;
	localparam int WARM_CYCLES      = WARMUP_ROUNDS / ROUNDS_PER_CYCLE;
	localparam int CNT_W            = $clog2(WARM_CYCLES);

	// config port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int LOW_W      = 64;
	localparam int HIGH_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd3;

	// request codes
	localparam logic REQ_RESTART = 1'b0;
	localparam logic REQ_DATA    = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // load state from key and IV
		logic step;     // run one group of rounds
		logic capture;  // register the result byte
	} trv_cmd_t;

	// Initial state: bit j of a 80-bit field is bit 7-j%8 of byte 9-j/8.
	function automatic logic [STATE_BITS-1:0] load_state(
		input logic [KEY_BITS-1:0] key,
		input logic [KEY_BITS-1:0] iv
	);
		logic [STATE_BITS-1:0] s;
		s = '0;
		for (int j = 0; j < KEY_BITS; j++) begin
			s[j]           = key[8 * (9 - j / 8) + 7 - j % 8];
			s[IV_BASE + j] = iv[8 * (9 - j / 8) + 7 - j % 8];
		end
		s[285] = 1'b1;
		s[286] = 1'b1;
		s[287] = 1'b1;
		return s;
	endfunction

endpackage

@@ sv/trv_if.sv @@
// Valid/ready channel interfaces for input requests and result beats.
// Depends on nothing.
interface trv_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output req_type, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input req_type, input data_byte, input last_byte,
		output ready);
endinterface

interface trv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

@@ sv/trv_datapath.sv @@
// Trivium datapath: key/IV registers, 288-bit state, eight unrolled rounds, result register.
// Depends on trv_pkg.
module trv_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  trv_pkg::trv_cmd_t                    cmd,
	input  logic                                 cfg_we,
	input  logic [trv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [trv_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [7:0]                           data_byte,
	input  logic                                 last_byte,
	output logic [7:0]                           out_byte,
	output logic                                 last_out
);

	logic [trv_pkg::LOW_W-1:0]      key_low_q, iv_low_q;
	logic [trv_pkg::HIGH_W-1:0]     key_high_q, iv_high_q;
	logic [trv_pkg::STATE_BITS-1:0] state_q;
	logic [trv_pkg::STATE_BITS-1:0] state_nxt;
	logic [trv_pkg::ROUNDS_PER_CYCLE-1:0] ks;
	logic [7:0] out_byte_q;
	logic       last_out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				trv_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				trv_pkg::REG_KEY_HIGH: key_high_q <= cfg_data[trv_pkg::HIGH_W-1:0];
				trv_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				trv_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data[trv_pkg::HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// eight rounds, first keystream bit in bit 0
	always_comb begin
		logic [trv_pkg::STATE_BITS-1:0] s;
		logic t1, t2, t3;
		s  = state_q;
		ks = '0;
		for (int i = 0; i < trv_pkg::ROUNDS_PER_CYCLE; i++) begin
			t1    = s[65] ^ s[92];
			t2    = s[161] ^ s[176];
			t3    = s[242] ^ s[287];
			ks[i] = t1 ^ t2 ^ t3;
			t1    = t1 ^ (s[90] & s[91]) ^ s[170];
			t2    = t2 ^ (s[174] & s[175]) ^ s[263];
			t3    = t3 ^ (s[285] & s[286]) ^ s[68];
			s     = {s[trv_pkg::STATE_BITS-2:0], t3};
			s[93]  = t1;
			s[177] = t2;
		end
		state_nxt = s;
	end

	// cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load) begin
			state_q <= trv_pkg::load_state({key_high_q, key_low_q}, {iv_high_q, iv_low_q});
		end else if (cmd.step) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_byte_q <= data_byte ^ ks;
			last_out_q <= last_byte;
		end
	end

	assign out_byte = out_byte_q;
	assign last_out = last_out_q;

endmodule

@@ sv/trv_ctrl.sv @@
// Trivium controller: handshakes, warm-up counter and result valid.
// Depends on trv_pkg.
module trv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req_type,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output trv_pkg::trv_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WARM = 1'b1;

	logic                      state_q;
	logic [trv_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      acc;

	// take a beat only when idle and the result slot is free or draining
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd.load    = acc && (in_req_type == trv_pkg::REQ_RESTART);
		cmd.capture = acc && (in_req_type == trv_pkg::REQ_DATA);
		cmd.step    = cmd.capture || (state_q == ST_WARM);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WARM;
						cnt_q   <= trv_pkg::CNT_W'(trv_pkg::WARM_CYCLES - 1);
					end
				end
				ST_WARM: begin
					if (cnt_q == '0) state_q <= ST_IDLE;
					else cnt_q <= cnt_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.capture) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/trivium_keystream_cipher.sv @@
// Trivium-80 keystream block. Write key and IV through the config port, then send a
// restart beat: the block loads its state and runs 1152 warm-up rounds, eight per
// cycle, accepting nothing until the warm-up is done, and gives no result for the
// restart beat. Each data beat yields one result beat (byte XOR eight keystream
// bits, last flag passed through); with the output taken every cycle, data beats
// stream at one per cycle. The eight unrolled rounds set the warm-up rate. Config
// writes take effect at the next restart.
// Depends on trv_pkg, trv_if, trv_ctrl, trv_datapath.
module trivium_keystream_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	trv_in_if.sink                         in_ch,
	trv_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [trv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trv_pkg::CFG_DATA_W-1:0] cfg_data
);

	trv_pkg::trv_cmd_t cmd;

	trv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_req_type(in_ch.req_type),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.cmd        (cmd)
	);

	trv_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data_byte (in_ch.data_byte),
		.last_byte (in_ch.last_byte),
		.out_byte  (out_ch.out_byte),
		.last_out  (out_ch.last_out)
	);

endmodule
